// ===== rtl/tsb_pkg.sv =====
// Shared types and constants for the texture slot batcher.
// Used by every module of the block; no dependencies.
package tsb_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int SLOT_IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int USED_W     = $clog2(SLOT_COUNT + 1);
    localparam int ACT_W      = 6;
    localparam int CMP_W      = (USED_W > ACT_W) ? USED_W : ACT_W;

    localparam int TEX_W      = 32;
    localparam int SLOTF_W    = 7;
    localparam int DRAW_W     = 16;
    localparam int INDEX_W    = 24;
    localparam int VIDX_W     = 5;
    localparam int CORNER_W   = 2;

    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CW       = $clog2(Q_DEPTH + 1);

    localparam logic [ACT_W-1:0]    ACTIVE_RESET     = 6'd16;
    localparam logic [DRAW_W-1:0]   DRAW_RESET       = 16'd1;
    localparam logic [DRAW_W-1:0]   DRAW_MAX         = 16'hFFFF;
    localparam logic [INDEX_W-1:0]  INDEX_MAX        = 24'hFFFFFF;
    localparam logic [INDEX_W-1:0]  INDICES_PER_FACE = 24'd6;
    localparam logic [CORNER_W-1:0] CORNER_LAST      = 2'd3;

    typedef enum logic [0:0] {
        KIND_START = 1'b0,
        KIND_FACE  = 1'b1
    } t_kind;

    typedef struct packed {
        logic [0:0]       cmd;
        logic [TEX_W-1:0] texture_id;
        logic [4:0]       pos_x;
        logic [6:0]       pos_y;
        logic [4:0]       pos_z;
        logic [1:0]       rotation;
        logic [2:0]       face_index;
    } t_item;

    typedef struct packed {
        logic [30:0]        vertex_word;
        logic [DRAW_W-1:0]  draw_call;
        logic [INDEX_W-1:0] index_total;
        logic [0:0]         new_batch;
        logic [0:0]         texture_added;
        logic [0:0]         last;
    } t_result;

    typedef struct packed {
        t_kind            kind;
        logic [TEX_W-1:0] texture_id;
        logic [4:0]       pos_x;
        logic [6:0]       pos_y;
        logic [4:0]       pos_z;
        logic [1:0]       rotation;
        logic [2:0]       face_index;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_head;

    typedef struct packed {
        logic [4:0]         pos_x;
        logic [6:0]         pos_y;
        logic [4:0]         pos_z;
        logic [1:0]         rotation;
        logic [2:0]         face_index;
        logic [SLOTF_W-1:0] slot;
        logic [DRAW_W-1:0]  draw_call;
        logic [INDEX_W-1:0] index_total;
        logic               new_batch;
        logic               texture_added;
    } t_emit_cmd;

endpackage

// ===== rtl/tsb_front.sv =====
// Front end: takes command transactions, classifies them and queues them.
// Depends on tsb_pkg.
module tsb_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  tsb_pkg::t_item  i_item,
    output tsb_pkg::t_q_head o_head,
    input  logic            i_pop
);

    tsb_pkg::t_entry                 r_mem [tsb_pkg::Q_DEPTH];
    logic [tsb_pkg::Q_AW-1:0]        r_wr, n_wr;
    logic [tsb_pkg::Q_AW-1:0]        r_rd, n_rd;
    logic [tsb_pkg::Q_CW-1:0]        r_cnt, n_cnt;
    logic                            push;
    logic                            pop;
    tsb_pkg::t_entry                 entry;

    assign busy = (r_cnt == tsb_pkg::Q_CW'(tsb_pkg::Q_DEPTH));
    assign push = start && !busy;
    assign pop  = i_pop && (r_cnt != '0);

    always_comb begin
        entry.kind       = i_item.cmd[0] ? tsb_pkg::KIND_FACE : tsb_pkg::KIND_START;
        entry.texture_id = i_item.texture_id;
        entry.pos_x      = i_item.pos_x;
        entry.pos_y      = i_item.pos_y;
        entry.pos_z      = i_item.pos_z;
        entry.rotation   = i_item.rotation;
        entry.face_index = i_item.face_index;
    end

    always_comb begin
        n_wr  = push ? r_wr + 1'b1 : r_wr;
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.entry = r_mem[r_rd];

endmodule

// ===== rtl/tsb_resolve.sv =====
// Back end: slot table lookup, batch bookkeeping and the slot-count register.
// Depends on tsb_pkg; feeds tsb_emit.
module tsb_resolve (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tsb_pkg::ACT_W-1:0]    i_cfg_data,
    input  tsb_pkg::t_q_head             i_head,
    output logic                         o_pop,
    input  logic                         i_emit_free,
    output logic                         o_emit_load,
    output tsb_pkg::t_emit_cmd           o_emit_cmd
);

    logic [tsb_pkg::TEX_W-1:0]      r_table [tsb_pkg::SLOT_COUNT];
    logic [tsb_pkg::ACT_W-1:0]      r_active;
    logic [tsb_pkg::USED_W-1:0]     r_used, n_used;
    logic [tsb_pkg::DRAW_W-1:0]     r_draw, n_draw;
    logic [tsb_pkg::INDEX_W-1:0]    r_index, n_index;
    logic                           r_m_valid;
    tsb_pkg::t_entry                r_m_entry;
    logic [tsb_pkg::SLOT_COUNT-1:0] r_m_match, n_match;

    logic                           resolve;
    logic                           found;
    logic [tsb_pkg::SLOT_IW-1:0]    enc;
    logic [tsb_pkg::CMP_W-1:0]      act_ext, used_ext, usable;
    logic                           full;
    logic                           opened;
    logic [tsb_pkg::USED_W-1:0]     used_eff;
    logic [tsb_pkg::INDEX_W-1:0]    index_base;
    logic [tsb_pkg::SLOT_IW-1:0]    slot;
    logic                           wr_en;

    assign o_cfg_ready = 1'b1;
    assign o_pop       = !r_m_valid;
    assign resolve     = r_m_valid &&
                         (r_m_entry.kind == tsb_pkg::KIND_START || i_emit_free);

    always_comb begin
        for (int i = 0; i < tsb_pkg::SLOT_COUNT; i++) begin
            n_match[i] = (r_table[i] == i_head.entry.texture_id) &&
                         (tsb_pkg::USED_W'(i) < r_used);
        end
    end

    always_comb begin
        enc = '0;
        for (int i = tsb_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_m_match[i]) begin
                enc = tsb_pkg::SLOT_IW'(i);
            end
        end
    end

    always_comb begin
        found    = |r_m_match;
        act_ext  = tsb_pkg::CMP_W'(r_active);
        used_ext = tsb_pkg::CMP_W'(r_used);
        if (act_ext == '0) begin
            usable = tsb_pkg::CMP_W'(1);
        end else if (act_ext > tsb_pkg::CMP_W'(tsb_pkg::SLOT_COUNT)) begin
            usable = tsb_pkg::CMP_W'(tsb_pkg::SLOT_COUNT);
        end else begin
            usable = act_ext;
        end
        full   = (used_ext >= usable);
        opened = !found && full;

        used_eff   = opened ? '0 : r_used;
        index_base = opened ? '0 : r_index;
        slot       = found ? enc : used_eff[tsb_pkg::SLOT_IW-1:0];
        wr_en      = resolve && (r_m_entry.kind == tsb_pkg::KIND_FACE) && !found &&
                     (used_eff < tsb_pkg::USED_W'(tsb_pkg::SLOT_COUNT));

        n_used  = r_used;
        n_draw  = r_draw;
        n_index = r_index;
        if (resolve) begin
            if (r_m_entry.kind == tsb_pkg::KIND_START) begin
                n_used  = '0;
                n_draw  = tsb_pkg::DRAW_RESET;
                n_index = '0;
            end else begin
                n_used = wr_en ? used_eff + 1'b1 : used_eff;
                if (opened && r_draw != tsb_pkg::DRAW_MAX) begin
                    n_draw = r_draw + 1'b1;
                end
                if (index_base > tsb_pkg::INDEX_MAX - tsb_pkg::INDICES_PER_FACE) begin
                    n_index = tsb_pkg::INDEX_MAX;
                end else begin
                    n_index = index_base + tsb_pkg::INDICES_PER_FACE;
                end
            end
        end
    end

    always_comb begin
        o_emit_load              = resolve && (r_m_entry.kind == tsb_pkg::KIND_FACE);
        o_emit_cmd.pos_x         = r_m_entry.pos_x;
        o_emit_cmd.pos_y         = r_m_entry.pos_y;
        o_emit_cmd.pos_z         = r_m_entry.pos_z;
        o_emit_cmd.rotation      = r_m_entry.rotation;
        o_emit_cmd.face_index    = r_m_entry.face_index;
        o_emit_cmd.slot          = tsb_pkg::SLOTF_W'(slot);
        o_emit_cmd.draw_call     = n_draw - 1'b1;
        o_emit_cmd.index_total   = n_index;
        o_emit_cmd.new_batch     = opened;
        o_emit_cmd.texture_added = !found;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[used_eff[tsb_pkg::SLOT_IW-1:0]] <= r_m_entry.texture_id;
        end
        if (!r_m_valid) begin
            r_m_entry <= i_head.entry;
            r_m_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= tsb_pkg::ACTIVE_RESET;
            r_used    <= '0;
            r_draw    <= tsb_pkg::DRAW_RESET;
            r_index   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
            r_used  <= n_used;
            r_draw  <= n_draw;
            r_index <= n_index;
            if (!r_m_valid) begin
                r_m_valid <= i_head.valid;
            end else if (resolve) begin
                r_m_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/tsb_emit.sv =====
// Corner sequencer: expands one resolved face into four vertex transactions.
// Depends on tsb_pkg; driven by tsb_resolve.
module tsb_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  tsb_pkg::t_emit_cmd i_cmd,
    output logic               o_free,
    output logic               o_strobe,
    output tsb_pkg::t_result   o_result
);

    tsb_pkg::t_emit_cmd              r_cmd;
    logic                            r_busy;
    logic [tsb_pkg::CORNER_W-1:0]    r_corner;
    logic [tsb_pkg::VIDX_W-1:0]      vidx;

    assign o_free = !r_busy || (r_corner == tsb_pkg::CORNER_LAST);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_corner <= '0;
        end else if (i_load) begin
            r_busy   <= 1'b1;
            r_corner <= '0;
        end else if (r_busy) begin
            if (r_corner == tsb_pkg::CORNER_LAST) begin
                r_busy <= 1'b0;
            end
            r_corner <= r_corner + 1'b1;
        end
    end

    assign vidx = {r_cmd.face_index, r_corner};

    always_comb begin
        o_strobe               = r_busy;
        o_result.vertex_word   = {r_cmd.slot, vidx, r_cmd.rotation,
                                  r_cmd.pos_z, r_cmd.pos_y, r_cmd.pos_x};
        o_result.draw_call     = r_cmd.draw_call;
        o_result.index_total   = r_cmd.index_total;
        o_result.new_batch     = r_cmd.new_batch;
        o_result.texture_added = r_cmd.texture_added;
        o_result.last          = (r_corner == tsb_pkg::CORNER_LAST);
    end

endmodule

// ===== rtl/texture_slot_batcher_top.sv =====
// A face accepted into the queue passes the resolve register and then the emit command
// register before its vertex strobes; a start command resolves without waiting for the emitter.
// Throughput is set by the four-corner emit sequencer, which takes a new face in its last corner.
// A four-entry queue sits between front and back; busy is high while it is full.
// Synchronous active-low reset empties the queue, resets the batch and sets 16 slots.
// Top level: ties tsb_front, tsb_resolve and tsb_emit together; uses tsb_pkg.
module texture_slot_batcher_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  tsb_pkg::t_item            i_item,
    output logic                      o_strobe,
    output tsb_pkg::t_result          o_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [tsb_pkg::ACT_W-1:0] i_cfg_data
);

    tsb_pkg::t_q_head   head;
    logic               pop;
    logic               emit_free;
    logic               emit_load;
    tsb_pkg::t_emit_cmd emit_cmd;

    tsb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_head  (head),
        .i_pop   (pop)
    );

    tsb_resolve u_resolve (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_head      (head),
        .o_pop       (pop),
        .i_emit_free (emit_free),
        .o_emit_load (emit_load),
        .o_emit_cmd  (emit_cmd)
    );

    tsb_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit_load),
        .i_cmd    (emit_cmd),
        .o_free   (emit_free),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
